// ===== src/ccc_pkg.sv =====
package ccc_pkg;

  localparam int CoordW = 32;
  localparam int RadW = 30;
  localparam int DepthW = 31;
  localparam int NormW = 18;
  localparam int SqW = 64;
  localparam int DistW = 32;
  localparam int FracBits = 16;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        zero;
    logic        sx;
    logic        sy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [29:0] ra;
    logic [30:0] rsum;
    logic [31:0] mx;
    logic [31:0] my;
  } ccc_item_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } ccc_sqrt_t;

  typedef struct packed {
    logic [48:0] rem;
    logic [32:0] quo;
  } ccc_div_t;

endpackage

// ===== src/ccc_sqrt_cell.sv =====
module ccc_sqrt_cell
  import ccc_pkg::*;
#(
  parameter int Step = 0
) (
  input  logic      clk,
  input  ccc_sqrt_t in_s,
  output ccc_sqrt_t out_s
);

  localparam int Sh = 2 * (31 - Step);
  localparam int Sr = 31 - Step;

  logic [63:0] trial;
  logic [63:0] cand;
  ccc_sqrt_t   out_nxt;

  always_comb begin
    trial = {32'd0, in_s.root} << Sr;
    cand = (trial << 1) | (64'd1 << Sh);
    out_nxt = in_s;
    if (in_s.rem >= cand) begin
      out_nxt.rem = in_s.rem - cand;
      out_nxt.root = in_s.root | (32'd1 << (31 - Step));
    end
  end

  always_ff @(posedge clk) begin
    out_s <= out_nxt;
  end

endmodule

// ===== src/ccc_div_cell.sv =====
module ccc_div_cell
  import ccc_pkg::*;
#(
  parameter int Step = 0
) (
  input  logic        clk,
  input  logic [31:0] divisor,
  input  ccc_div_t    in_s,
  output ccc_div_t    out_s
);

  localparam int Sh = 32 - Step;

  logic [81:0] cand;
  ccc_div_t    out_nxt;

  always_comb begin
    cand = {50'd0, divisor} << Sh;
    out_nxt = in_s;
    if ({33'd0, in_s.rem} >= cand) begin
      out_nxt.rem = in_s.rem - cand[48:0];
      out_nxt.quo = in_s.quo | (33'd1 << Sh);
    end
  end

  always_ff @(posedge clk) begin
    out_s <= out_nxt;
  end

endmodule

// ===== src/circle_circle_contact_core.sv =====
// Circle pair contact generator.
// Drive the six in_ fields with start high; busy is always low, so a new
// pair transfers at every rising edge with start high, one per cycle.
// Each pair yields one result on the out_ ports, marked by out_valid for
// one cycle, after it passes through 3 front stages, 32 stages of
// the square-root chain (one root bit per cell), 33 stages of the division
// chain (one quotient bit per cell, x and y in parallel) and 2 stages for
// scaling and saturation, 70 register stages in all. The first stage
// loads at the transfer edge.
// Results leave in transfer order. The receiver cannot stall the block.
// Synchronous reset clears the valid marks in every stage; pairs in flight
// are dropped. A miss returns all fields zero; coincident centres return
// radius A as depth, normal (1,0) and contact at centre A.
module circle_circle_contact_core
  import ccc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_center_a_x,
  input  logic signed [31:0] in_center_a_y,
  input  logic signed [31:0] in_center_b_x,
  input  logic signed [31:0] in_center_b_y,
  input  logic [29:0]        in_radius_a,
  input  logic [29:0]        in_radius_b,
  output logic               out_valid,
  output logic               out_hit,
  output logic [30:0]        out_depth,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [31:0] out_contact_x,
  output logic signed [31:0] out_contact_y
);

  localparam int SqN = 32;
  localparam int DvN = 33;
  localparam int Lat = 3 + SqN + DvN;

  logic signed [32:0] dx_r, dy_r;
  logic [31:0] ax_r, ay_r;
  logic [29:0] ra_r;
  logic [30:0] rsum_r;
  logic v0_r;
  logic [63:0] x2_r, y2_r, r2_r;
  ccc_item_t line_r [Lat];
  ccc_item_t line_nxt [Lat];
  logic [63:0] d2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    dx_r <= 33'(in_center_b_x) - 33'(in_center_a_x);
    dy_r <= 33'(in_center_b_y) - 33'(in_center_a_y);
    ax_r <= in_center_a_x;
    ay_r <= in_center_a_y;
    ra_r <= in_radius_a;
    rsum_r <= 31'(in_radius_a) + 31'(in_radius_b);
    x2_r <= 64'(line_r[0].mx) * 64'(line_r[0].mx);
    y2_r <= 64'(line_r[0].my) * 64'(line_r[0].my);
    r2_r <= 64'(line_r[0].rsum) * 64'(line_r[0].rsum);
    for (int i = 0; i < Lat; i++) begin
      line_r[i] <= line_nxt[i];
    end
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_comb begin
    d2 = x2_r + y2_r;
    line_nxt[0] = '0;
    line_nxt[0].valid = v0_r;
    line_nxt[0].hit = !((dx_r > 33'sd2147483647) || (dx_r < -33'sd2147483647) ||
                        (dy_r > 33'sd2147483647) || (dy_r < -33'sd2147483647));
    line_nxt[0].sx = dx_r[32];
    line_nxt[0].sy = dy_r[32];
    line_nxt[0].ax = ax_r;
    line_nxt[0].ay = ay_r;
    line_nxt[0].ra = ra_r;
    line_nxt[0].rsum = rsum_r;
    line_nxt[0].mx = dx_r[32] ? 32'(-dx_r) : dx_r[31:0];
    line_nxt[0].my = dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
    for (int i = 1; i < Lat; i++) begin
      line_nxt[i] = line_r[i-1];
    end
    line_nxt[2].hit = line_r[1].hit && (d2 < r2_r);
    line_nxt[2].zero = (d2 == 64'd0);
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) begin
        line_nxt[i].valid = 1'b0;
      end
    end
  end

  ccc_sqrt_t sq [SqN+1];
  always_comb begin
    sq[0].rem = d2;
    sq[0].root = '0;
  end

  // The remainder chain is the plain bitwise root; the root word is built MSB first.
  for (genvar g = 0; g < SqN; g++) begin : g_sq
    ccc_sqrt_cell #(.Step(g)) u_cell (.clk(clk), .in_s(sq[g]), .out_s(sq[g+1]));
  end

  logic [31:0] dist_line [DvN+1];
  ccc_div_t dvx [DvN+1];
  ccc_div_t dvy [DvN+1];
  ccc_item_t tq;
  assign tq = line_r[1 + SqN];

  always_comb begin
    dist_line[0] = sq[SqN].root;
    dvx[0].rem = (49'(tq.mx) << FracBits) + 49'(sq[SqN].root >> 1);
    dvx[0].quo = '0;
    dvy[0].rem = (49'(tq.my) << FracBits) + 49'(sq[SqN].root >> 1);
    dvy[0].quo = '0;
  end

  for (genvar g = 0; g < DvN; g++) begin : g_dv
    always_ff @(posedge clk) begin
      dist_line[g+1] <= dist_line[g];
    end
    ccc_div_cell #(.Step(g)) u_x (.clk(clk), .divisor(dist_line[g]), .in_s(dvx[g]),
                                  .out_s(dvx[g+1]));
    ccc_div_cell #(.Step(g)) u_y (.clk(clk), .divisor(dist_line[g]), .in_s(dvy[g]),
                                  .out_s(dvy[g+1]));
  end

  ccc_item_t td;
  assign td = line_r[1 + SqN + DvN];

  logic [16:0] qx, qy;
  logic [46:0] px_r, py_r;
  logic [31:0] dist_r;
  logic hit_r, zero_r, sx_r, sy_r, v_r;
  logic [16:0] qx_r, qy_r;
  logic [31:0] cax_r, cay_r;
  logic [30:0] rsum2_r;
  logic [29:0] ra2_r;

  assign qx = dvx[DvN].quo[16:0];
  assign qy = dvy[DvN].quo[16:0];

  always_ff @(posedge clk) begin
    px_r <= 47'(qx) * 47'(td.ra);
    py_r <= 47'(qy) * 47'(td.ra);
    dist_r <= dist_line[DvN];
    hit_r <= td.hit;
    zero_r <= td.zero;
    sx_r <= td.sx;
    sy_r <= td.sy;
    qx_r <= qx;
    qy_r <= qy;
    cax_r <= td.ax;
    cay_r <= td.ay;
    rsum2_r <= td.rsum;
    ra2_r <= td.ra;
    v_r <= rst_n && td.valid;
  end

  logic [46:0] mgx, mgy;
  logic signed [33:0] cx, cy;
  logic signed [31:0] satx, saty;
  always_comb begin
    mgx = (px_r + (47'd1 << (FracBits - 1))) >> FracBits;
    mgy = (py_r + (47'd1 << (FracBits - 1))) >> FracBits;
    cx = 34'($signed(cax_r)) + (sx_r ? -$signed({1'b0, mgx[32:0]})
                                     : $signed({1'b0, mgx[32:0]}));
    cy = 34'($signed(cay_r)) + (sy_r ? -$signed({1'b0, mgy[32:0]})
                                     : $signed({1'b0, mgy[32:0]}));
    satx = (cx > 34'sd2147483647) ? 32'h7fffffff :
           (cx < -34'sd2147483648) ? 32'h80000000 : cx[31:0];
    saty = (cy > 34'sd2147483647) ? 32'h7fffffff :
           (cy < -34'sd2147483648) ? 32'h80000000 : cy[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r;
    end
    out_hit <= hit_r;
    out_depth <= '0;
    out_normal_x <= '0;
    out_normal_y <= '0;
    out_contact_x <= '0;
    out_contact_y <= '0;
    if (hit_r && zero_r) begin
      out_depth <= 31'(ra2_r);
      out_normal_x <= 18'sd1 <<< FracBits;
      out_contact_x <= cax_r;
      out_contact_y <= cay_r;
    end else if (hit_r) begin
      out_depth <= rsum2_r - dist_r[30:0];
      out_normal_x <= sx_r ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
      out_normal_y <= sy_r ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
      out_contact_x <= satx;
      out_contact_y <= saty;
    end
  end

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_depth == '0 && out_contact_x == '0)
    else $error("miss not zero");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(line_r[Lat-1].valid)) else $error("stray result");
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_normal_x <= 18'sd65536 && out_normal_x >= -18'sd65536 &&
                             out_normal_y <= 18'sd65536 && out_normal_y >= -18'sd65536)
    else $error("normal out of range");
`endif

endmodule
